// ===== hw/rtl/jsu_pkg.sv =====
// jsu_pkg: shared types and constants for the json string unescaper
// result kinds, error codes and the result bundle passed from core to emitter
// no dependencies
`timescale 1ns / 1ps

package jsu_pkg;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_END     = 3'd1,
        ERR_QUOTE   = 3'd2,
        ERR_ESCAPE  = 3'd3,
        ERR_UNICODE = 3'd4
    } t_err;

    // utf-8 encoding limits and marks
    localparam logic [15:0] UTF8_LIMIT1 = 16'h0080;
    localparam logic [15:0] UTF8_LIMIT2 = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
    localparam logic [7:0]  UTF8_CONT   = 8'h80;
    localparam logic [5:0]  UTF8_MASK6  = 6'h3F;

    localparam int MAX_RESULTS = 3;

    // all results caused by one input beat
    typedef struct packed {
        logic [1:0]                   count;  // 0..3 beats
        logic [MAX_RESULTS-1:0][7:0]  bytes;  // bytes[0] goes out first
        t_kind                        kind;
        t_err                         err;
    } t_bundle;

endpackage

// ===== hw/rtl/jsu_core.sv =====
// jsu_core: parser state and single-pass decode of one input byte
// produces the bundle of results for the byte; depends on jsu_pkg
`timescale 1ns / 1ps

module jsu_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [7:0]       i_byte,
    input  logic             i_eoi,
    output jsu_pkg::t_bundle o_bundle
);

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_STR  = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } t_phase;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic [15:0] r_cp, n_cp;
    logic        r_bad, n_bad;

    logic        hex_ok;
    logic [3:0]  hex_val;

    // hex digit decode
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hex_val = 4'(i_byte - 8'h30);
        end else if (i_byte >= 8'h61 && i_byte <= 8'h66) begin
            hex_val = 4'(i_byte - 8'h57);
        end else if (i_byte >= 8'h41 && i_byte <= 8'h46) begin
            hex_val = 4'(i_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_hex_cnt = r_hex_cnt;
        n_cp      = r_cp;
        n_bad     = r_bad;
        o_bundle  = '{count: 2'd0, bytes: '0, kind: jsu_pkg::KIND_DATA,
                      err: jsu_pkg::ERR_NONE};
        if (i_eoi) begin
            n_phase        = PH_WAIT;
            o_bundle.count = 2'd1;
            o_bundle.kind  = jsu_pkg::KIND_ERR;
            o_bundle.err   = jsu_pkg::ERR_END;
        end else begin
            unique case (r_phase)
                PH_WAIT: begin
                    if (i_byte == CH_QUOTE) begin
                        n_phase = PH_STR;
                    end else begin
                        o_bundle.count = 2'd1;
                        o_bundle.kind  = jsu_pkg::KIND_ERR;
                        o_bundle.err   = jsu_pkg::ERR_QUOTE;
                    end
                end
                PH_STR: begin
                    if (i_byte == CH_QUOTE) begin
                        n_phase        = PH_WAIT;
                        o_bundle.count = 2'd1;
                        o_bundle.kind  = jsu_pkg::KIND_DONE;
                    end else if (i_byte == CH_BSL) begin
                        n_phase = PH_ESC;
                    end else begin
                        o_bundle.count    = 2'd1;
                        o_bundle.bytes[0] = i_byte;
                    end
                end
                PH_ESC: begin
                    priority if (i_byte == CH_N) begin
                        n_phase           = PH_STR;
                        o_bundle.count    = 2'd1;
                        o_bundle.bytes[0] = CH_LF;
                    end else if (i_byte == CH_R) begin
                        n_phase           = PH_STR;
                        o_bundle.count    = 2'd1;
                        o_bundle.bytes[0] = CH_CR;
                    end else if (i_byte == CH_BSL || i_byte == CH_SLASH
                                 || i_byte == CH_QUOTE) begin
                        n_phase           = PH_STR;
                        o_bundle.count    = 2'd1;
                        o_bundle.bytes[0] = i_byte;
                    end else if (i_byte == CH_U) begin
                        n_phase   = PH_HEX;
                        n_hex_cnt = 2'd0;
                        n_cp      = 16'd0;
                        n_bad     = 1'b0;
                    end else begin
                        n_phase        = PH_WAIT;
                        o_bundle.count = 2'd1;
                        o_bundle.kind  = jsu_pkg::KIND_ERR;
                        o_bundle.err   = jsu_pkg::ERR_ESCAPE;
                    end
                end
                PH_HEX: begin
                    if (hex_ok) begin
                        n_cp = {r_cp[11:0], hex_val};
                    end else begin
                        n_bad = 1'b1;
                    end
                    if (r_hex_cnt != 2'd3) begin
                        n_hex_cnt = r_hex_cnt + 2'd1;
                    end else begin
                        n_hex_cnt = 2'd0;
                        if (n_bad) begin
                            n_bad          = 1'b0;
                            n_phase        = PH_WAIT;
                            o_bundle.count = 2'd1;
                            o_bundle.kind  = jsu_pkg::KIND_ERR;
                            o_bundle.err   = jsu_pkg::ERR_UNICODE;
                        end else begin
                            n_phase = PH_STR;
                            // utf-8 encode of the finished code point
                            if (n_cp < jsu_pkg::UTF8_LIMIT1) begin
                                o_bundle.count    = 2'd1;
                                o_bundle.bytes[0] = n_cp[7:0];
                            end else if (n_cp < jsu_pkg::UTF8_LIMIT2) begin
                                o_bundle.count    = 2'd2;
                                o_bundle.bytes[0] = jsu_pkg::UTF8_LEAD2
                                                    | {3'd0, n_cp[10:6]};
                                o_bundle.bytes[1] = jsu_pkg::UTF8_CONT
                                                    | {2'd0, n_cp[5:0] & jsu_pkg::UTF8_MASK6};
                            end else begin
                                o_bundle.count    = 2'd3;
                                o_bundle.bytes[0] = jsu_pkg::UTF8_LEAD3
                                                    | {4'd0, n_cp[15:12]};
                                o_bundle.bytes[1] = jsu_pkg::UTF8_CONT
                                                    | {2'd0, n_cp[11:6]};
                                o_bundle.bytes[2] = jsu_pkg::UTF8_CONT
                                                    | {2'd0, n_cp[5:0] & jsu_pkg::UTF8_MASK6};
                            end
                        end
                    end
                end
                default: n_phase = PH_WAIT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_WAIT;
            r_hex_cnt <= 2'd0;
            r_cp      <= 16'd0;
            r_bad     <= 1'b0;
        end else if (i_adv) begin
            r_phase   <= n_phase;
            r_hex_cnt <= n_hex_cnt;
            r_cp      <= n_cp;
            r_bad     <= n_bad;
        end
    end

endmodule

// ===== hw/rtl/jsu_emit.sv =====
// jsu_emit: result register that sends a bundle out one beat at a time
// holds up to three result beats; depends on jsu_pkg
`timescale 1ns / 1ps

module jsu_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  jsu_pkg::t_bundle i_bundle,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_byte,
    output jsu_pkg::t_kind   o_kind,
    output jsu_pkg::t_err    o_err,
    output logic             o_last
);

    logic             r_valid;
    logic [1:0]       r_idx;
    jsu_pkg::t_bundle r_bun;

    assign o_last  = (r_idx == r_bun.count - 2'd1);
    assign o_free  = !r_valid || (i_ready && o_last);
    assign o_valid = r_valid;
    assign o_kind  = r_bun.kind;
    assign o_err   = r_bun.err;

    always_comb begin
        unique case (r_idx)
            2'd0:    o_byte = r_bun.bytes[0];
            2'd1:    o_byte = r_bun.bytes[1];
            2'd2:    o_byte = r_bun.bytes[2];
            default: o_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (r_valid && i_ready) begin
            if (o_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bun <= i_bundle;
        end
    end

endmodule

// ===== hw/rtl/json_string_unescaper.sv =====
// json_string_unescaper: top level of the json string unescaper
// input register, jsu_core decode and jsu_emit result register; depends on jsu_pkg
`timescale 1ns / 1ps

// Takes one raw byte (or an end-of-input marker in s_axis_tuser) per beat,
// waits for an opening quote, copies ordinary bytes, decodes the escapes
// \n \r \\ \/ \" and \uXXXX (sent as one to three utf-8 bytes), and reports
// the closing quote as a "string complete" beat. Errors (missing opening
// quote, unknown escape, non-hex character in a \u escape, early end) are
// sent as an error beat, after which the block waits for a new opening
// quote. A byte enters the input register, is decoded combinationally
// against the parser state and lands in the result register; a byte
// with no results moves on at once, one with results waits until the
// result register can take it. Each byte yields zero, one, or (for \u
// escapes above 0x7f) two or three output beats, one per cycle while
// m_axis_tready is high; the rate is one byte per cycle, but the input
// waits while extra utf-8 bytes go out. A byte's last beat has tlast.

module json_string_unescaper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last result of the input beat
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;

    logic             adv;
    logic             emit_free;
    jsu_pkg::t_bundle bundle;
    logic [7:0]       out_byte;
    jsu_pkg::t_kind   out_kind;
    jsu_pkg::t_err    out_err;

    // a beat with no results moves on regardless of the output side
    assign adv           = r_in_valid && (bundle.count == 2'd0 || emit_free);
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_eoi  <= s_axis_tuser;
        end
    end

    jsu_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_byte   (r_in_byte),
        .i_eoi    (r_in_eoi),
        .o_bundle (bundle)
    );

    jsu_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv && bundle.count != 2'd0),
        .i_bundle (bundle),
        .o_free   (emit_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_byte   (out_byte),
        .o_kind   (out_kind),
        .o_err    (out_err),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, out_err, out_byte};
    assign m_axis_tuser = out_kind;

    // error beats always carry a code
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == jsu_pkg::KIND_ERR
        |-> m_axis_tdata[10:8] != jsu_pkg::ERR_NONE)
        else $error("error beat without error code");

    // done and error beats are single and zero-byte
    a_ctl_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != jsu_pkg::KIND_DATA
        |-> m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
        else $error("control beat not last or has data");

    // data beats carry no error code
    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == jsu_pkg::KIND_DATA
        |-> m_axis_tdata[10:8] == jsu_pkg::ERR_NONE)
        else $error("data beat with error code");

    // a held input beat is not dropped
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_eoi))
        else $error("pending input beat lost");

endmodule
